FILE: rtl/core/fvcm_pkg.sv
// Shared types and constants for the four-voice chiptune mixer.
package fvcm_pkg;

	// Sequencer steps, one-hot coded.
	typedef enum logic [10:0] {
		ST_IDLE = 11'b000_0000_0001,
		ST_TRI  = 11'b000_0000_0010,
		ST_PUL  = 11'b000_0000_0100,
		ST_SQR  = 11'b000_0000_1000,
		ST_MX1  = 11'b000_0001_0000,
		ST_MX2  = 11'b000_0010_0000,
		ST_MX3  = 11'b000_0100_0000,
		ST_PCM  = 11'b000_1000_0000,
		ST_VOL  = 11'b001_0000_0000,
		ST_TICK = 11'b010_0000_0000,
		ST_DONE = 11'b100_0000_0000
	} step_t;

	// Control from the sequencer to the datapath.
	typedef struct packed {
		step_t step;
		logic  idle;
		logic  load_out;
	} ctrl_t;

	localparam int unsigned CfgIndexW = 2;
	localparam logic [CfgIndexW-1:0] REG_MASTER_VOLUME = 2'd0;
	localparam logic [CfgIndexW-1:0] REG_TICK_DIVISOR  = 2'd1;

	localparam logic [8:0]  MASTER_VOLUME_RESET = 9'd256;
	localparam logic [14:0] TICK_DIVISOR_RESET  = 15'd1250;
	localparam logic [15:0] NOISE_RESET         = 16'h0001;
	localparam logic [8:0]  UNITY_GAIN          = 9'd256;
	localparam logic [7:0]  MID_LEVEL           = 8'd128;
	localparam logic [7:0]  TOP_LEVEL           = 8'd255;

endpackage

FILE: rtl/core/fvcm_seq.sv
// Step sequencer for the mixer: walks one sample through the shared adder and multiplier.
module fvcm_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           start_hold,
	input  logic           out_free,
	output fvcm_pkg::ctrl_t ctrl
);
	import fvcm_pkg::*;

	step_t state_q;
	step_t state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = start_hold ? ST_DONE : ST_TRI;
				end
			end
			ST_TRI:  state_d = ST_PUL;
			ST_PUL:  state_d = ST_SQR;
			ST_SQR:  state_d = ST_MX1;
			ST_MX1:  state_d = ST_MX2;
			ST_MX2:  state_d = ST_MX3;
			ST_MX3:  state_d = ST_PCM;
			ST_PCM:  state_d = ST_VOL;
			ST_VOL:  state_d = ST_TICK;
			ST_TICK: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign ctrl.step     = state_q;
	assign ctrl.idle     = (state_q == ST_IDLE);
	assign ctrl.load_out = (state_q == ST_DONE) && out_free;

endmodule

FILE: rtl/core/four_voice_chiptune_mixer_top.sv
// Top level of the four-voice chiptune mixer: stream ports, registers and shared datapath.
// One input transfer yields one output sample. A normal item passes through nine steps on
// one shared 17-bit adder and one shared 10x10 signed multiplier, then its result is loaded
// into the output register; the input stays closed until then, so a new item is taken only
// after the last one is through. A held item goes straight to that load and returns 128
// with no tick. A new item is taken as soon as the result is in the output register, even
// while that result still waits downstream; a finished result that finds the output register
// still full waits there and holds the input. Configuration writes are always accepted, as
// cfg_ready is tied high, and should be made only while idle.
module four_voice_chiptune_mixer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// triangle_freq[15:0], triangle_vol[23:16], pulse_freq[39:24], pulse_vol[47:40],
	// square_freq[63:48], square_vol[71:64], noise_vol[79:72], pcm_level[87:80]
	input  logic [87:0] s_axis_tdata,
	// hold[0]
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// sample[7:0]
	output logic [7:0]  m_axis_tdata,
	// tick[0]
	output logic        m_axis_tuser,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [fvcm_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [14:0] cfg_data
);
	import fvcm_pkg::*;

	ctrl_t ctrl;
	logic  s_fire;
	logic  out_free;

	// Configuration and item registers.
	logic [8:0]  master_volume_q;
	logic [14:0] tick_divisor_q;
	logic [87:0] item_q;
	logic        hold_q;

	// Voice state.
	logic [15:0] tri_phase_q;
	logic [15:0] pulse_phase_q;
	logic [15:0] square_phase_q;
	logic [15:0] noise_q;
	logic [14:0] tick_count_q;

	// Working registers.
	logic [7:0]         mix_q;
	logic signed [9:0]  c_q;
	logic signed [19:0] prod_q;
	logic [7:0]         sample_q;
	logic               tick_q;

	logic [7:0]  m_data_q;
	logic        m_user_q;
	logic        m_valid_q;

	// Item fields.
	logic [15:0] tri_freq, pulse_freq, square_freq;
	logic [7:0]  tri_vol, pulse_vol, square_vol, noise_vol, pcm_level;

	assign tri_freq    = item_q[15:0];
	assign tri_vol     = item_q[23:16];
	assign pulse_freq  = item_q[39:24];
	assign pulse_vol   = item_q[47:40];
	assign square_freq = item_q[63:48];
	assign square_vol  = item_q[71:64];
	assign noise_vol   = item_q[79:72];
	assign pcm_level   = item_q[87:80];

	assign s_axis_tready = ctrl.idle;
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign cfg_ready     = 1'b1;

	fvcm_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (s_fire),
		.start_hold(s_axis_tuser),
		.out_free  (out_free),
		.ctrl      (ctrl)
	);

	// Voice contributions.
	logic [7:0] tri_b, tri_fold, tri_p;
	logic [7:0] pulse_term, square_term, noise_term;
	logic [8:0] gain;

	assign tri_b       = tri_phase_q[15:8];
	assign tri_fold    = tri_b[7] ? ~tri_b : tri_b;
	// Doubling then subtracting 128 flips the top bit of the doubled value.
	assign tri_p       = {tri_fold[6:0], 1'b0} ^ 8'h80;
	assign pulse_term  = (pulse_phase_q[15:14] == 2'b11) ? 8'(-pulse_vol) : pulse_vol;
	assign square_term = square_phase_q[15] ? 8'(-square_vol) : square_vol;
	assign noise_term  = noise_q[15] ? 8'(-noise_vol) : noise_vol;
	assign gain        = (master_volume_q > UNITY_GAIN) ? UNITY_GAIN : master_volume_q;

	// Shared adder.
	logic [15:0] add_a, add_b;
	logic [16:0] add_sum;
	logic [7:0]  pcm_off;

	assign pcm_off = pcm_level ^ MID_LEVEL;

	always_comb begin
		add_a = '0;
		add_b = '0;
		case (ctrl.step)
			ST_TRI: begin
				add_a = tri_phase_q;
				add_b = tri_freq;
			end
			ST_PUL: begin
				add_a = pulse_phase_q;
				add_b = pulse_freq;
			end
			ST_SQR: begin
				add_a = square_phase_q;
				add_b = square_freq;
			end
			ST_MX1: begin
				add_a = {8'd0, mix_q};
				add_b = {8'd0, pulse_term};
			end
			ST_MX2: begin
				add_a = {8'd0, mix_q};
				add_b = {8'd0, square_term};
			end
			ST_MX3: begin
				add_a = {8'd0, mix_q};
				add_b = {8'd0, noise_term};
			end
			ST_PCM: begin
				add_a = {{8{mix_q[7]}}, mix_q};
				add_b = {{8{pcm_off[7]}}, pcm_off};
			end
			ST_TICK: begin
				add_a = {1'b0, tick_count_q};
				add_b = 16'd1;
			end
			default: begin
				add_a = '0;
				add_b = '0;
			end
		endcase
	end

	assign add_sum = {1'b0, add_a} + {1'b0, add_b};

	// Shared multiplier.
	logic signed [9:0]  mul_a, mul_b;
	logic signed [19:0] mul_p;

	always_comb begin
		if (ctrl.step == ST_VOL) begin
			mul_a = c_q;
			mul_b = $signed({1'b0, gain});
		end else begin
			mul_a = $signed({{2{tri_p[7]}}, tri_p});
			mul_b = $signed({{2{tri_vol[7]}}, tri_vol});
		end
	end

	assign mul_p = mul_a * mul_b;

	// Scaled level: 128 plus the floor of the product over 256, clamped to 0..255.
	logic signed [11:0] level;
	logic [7:0]         clamped;

	assign level = prod_q[19:8];

	always_comb begin
		if (level < -12'sd128) begin
			clamped = 8'd0;
		end else if (level > 12'sd127) begin
			clamped = TOP_LEVEL;
		end else begin
			clamped = level[7:0] ^ MID_LEVEL;
		end
	end

	logic tick_wrap;
	assign tick_wrap = (add_sum[15:0] >= {1'b0, tick_divisor_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_volume_q <= MASTER_VOLUME_RESET;
			tick_divisor_q  <= TICK_DIVISOR_RESET;
			tri_phase_q     <= '0;
			pulse_phase_q   <= '0;
			square_phase_q  <= '0;
			noise_q         <= NOISE_RESET;
			tick_count_q    <= '0;
			m_valid_q       <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_MASTER_VOLUME: master_volume_q <= cfg_data[8:0];
					REG_TICK_DIVISOR:  tick_divisor_q  <= cfg_data;
					default: ;
				endcase
			end
			case (ctrl.step)
				ST_TRI: begin
					tri_phase_q <= add_sum[15:0];
					noise_q     <= {noise_q[14:0], noise_q[14] ^ noise_q[13]};
				end
				ST_PUL:  pulse_phase_q  <= add_sum[15:0];
				ST_SQR:  square_phase_q <= add_sum[15:0];
				ST_TICK: tick_count_q   <= tick_wrap ? 15'd0 : add_sum[14:0];
				default: ;
			endcase
			if (ctrl.load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (s_fire) begin
			item_q <= s_axis_tdata;
			hold_q <= s_axis_tuser;
		end
		case (ctrl.step)
			ST_PUL:  prod_q <= mul_p;
			ST_SQR:  mix_q  <= prod_q[14:7];
			ST_MX1,
			ST_MX2,
			ST_MX3:  mix_q  <= add_sum[7:0];
			ST_PCM:  c_q    <= $signed(add_sum[9:0]);
			ST_VOL:  prod_q <= mul_p;
			ST_TICK: begin
				sample_q <= clamped;
				tick_q   <= tick_wrap;
			end
			default: ;
		endcase
		if (ctrl.load_out) begin
			m_data_q <= hold_q ? MID_LEVEL : sample_q;
			m_user_q <= hold_q ? 1'b0 : tick_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

endmodule

FILE: rtl/core/fvcm_checker.sv
// Port-level checks for the four-voice chiptune mixer, bound to the top level.
module fvcm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata,
	input logic        m_axis_tuser
);
	logic s_fire;
	assign s_fire = s_axis_tvalid && s_axis_tready;

	// One item at a time: the input closes right after a transfer.
	assert property (@(posedge clk) disable iff (!arst_n) s_fire |=> !s_axis_tready)
		else $error("input still open after a transfer");

	// A normal item keeps the input closed at least until its tick step.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && !s_axis_tuser |-> ##9 !s_axis_tready)
		else $error("normal item finished too early");

	// A new result only appears after the block has been busy.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result appeared without work");

	// A stalled result holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

endmodule

bind four_voice_chiptune_mixer_top fvcm_checker u_fvcm_checker (.*);

FILE: tb/sv/fvcm_sample_checker.sv
// Request layout and the sample checker that predicts and compares every mixer output.
`timescale 1ns / 1ps

package fvcm_tb_pkg;

	// One sample request as carried on s_axis_tdata; the last member sits in the lowest bits.
	typedef struct packed {
		logic [7:0]  pcm_level;
		logic [7:0]  noise_vol;
		logic [7:0]  square_vol;
		logic [15:0] square_freq;
		logic [7:0]  pulse_vol;
		logic [15:0] pulse_freq;
		logic [7:0]  triangle_vol;
		logic [15:0] triangle_freq;
	} voice_req_t;

endpackage

module fvcm_sample_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [87:0] s_axis_tdata,
	input  logic        s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [7:0]  m_axis_tdata,
	input  logic        m_axis_tuser,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [fvcm_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [14:0] cfg_data,
	output int          fail_count,
	output int          pending
);
	import fvcm_pkg::*;
	import fvcm_tb_pkg::*;

	localparam logic [15:0] PULSE_EDGE = 16'hC000;

	typedef struct packed {
		logic [7:0] sample;
		logic       tick;
	} mix_out_t;

	mix_out_t    pending_samples[$];
	logic [8:0]  master_volume;
	logic [14:0] tick_divisor;
	logic [15:0] tri_phase;
	logic [15:0] pul_phase;
	logic [15:0] sqr_phase;
	logic [15:0] noise_sr;
	logic [15:0] tick_count;

	// A voice contributes its amplitude or the 8-bit negation of it; -128 negates to itself.
	function automatic logic [7:0] voice_amp(input logic [7:0] vol, input logic flip);
		return flip ? 8'd0 - vol : vol;
	endfunction

	function automatic mix_out_t mix_next_sample(input voice_req_t r);
		logic [7:0]        b;
		logic [7:0]        mix;
		logic signed [7:0] tri_lvl;
		logic [15:0]       q;
		logic [8:0]        gain;
		int                prod;
		int                lvl;
		int                acc;
		mix_out_t          o;

		tri_phase = tri_phase + r.triangle_freq;
		b = tri_phase[15:8];
		if (b[7]) begin
			b = ~b;
		end
		b = {b[6:0], 1'b0} - MID_LEVEL;
		tri_lvl = b;
		prod = tri_lvl * $signed(r.triangle_vol) * 2;
		// Bits 15:8 of the product are the floor of a division by 256, kept to 8 bits.
		mix = prod[15:8];

		pul_phase = pul_phase + r.pulse_freq;
		mix = mix + voice_amp(r.pulse_vol, pul_phase >= PULSE_EDGE);

		sqr_phase = sqr_phase + r.square_freq;
		mix = mix + voice_amp(r.square_vol, sqr_phase[15]);

		q = {noise_sr[14:0], 1'b0};
		q[0] = q[15] ^ q[14];
		noise_sr = q;
		mix = mix + voice_amp(r.noise_vol, q[15]);

		lvl = $signed(mix);
		lvl = lvl + r.pcm_level - MID_LEVEL;
		gain = (master_volume > UNITY_GAIN) ? UNITY_GAIN : master_volume;
		acc = int'(MID_LEVEL) * 256 + lvl * int'(gain);
		if (acc < 0) begin
			o.sample = 8'd0;
		end else if ((acc >>> 8) > int'(TOP_LEVEL)) begin
			o.sample = TOP_LEVEL;
		end else begin
			o.sample = acc[15:8];
		end

		tick_count = tick_count + 16'd1;
		o.tick = (tick_count >= {1'b0, tick_divisor});
		if (o.tick) begin
			tick_count = '0;
		end
		tick_count[15] = 1'b0;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		mix_out_t got;
		mix_out_t want;

		if (!arst_n) begin
			master_volume = MASTER_VOLUME_RESET;
			tick_divisor  = TICK_DIVISOR_RESET;
			tri_phase     = '0;
			pul_phase     = '0;
			sqr_phase     = '0;
			noise_sr      = NOISE_RESET;
			tick_count    = '0;
			fail_count    = 0;
			pending_samples.delete();
		end else begin
			// Outputs are checked before the request of the same edge is predicted.
			if (m_axis_tvalid && m_axis_tready) begin
				got = {m_axis_tdata, m_axis_tuser};
				if (pending_samples.size() == 0) begin
					$error("output transfer with nothing expected: sample %0d tick %0b",
						got.sample, got.tick);
					fail_count++;
				end else begin
					want = pending_samples.pop_front();
					if (got.sample !== want.sample) begin
						$error("sample: expected %0d, actual %0d", want.sample, got.sample);
						fail_count++;
					end
					if (got.tick !== want.tick) begin
						$error("tick: expected %0b, actual %0b", want.tick, got.tick);
						fail_count++;
					end
				end
			end

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MASTER_VOLUME: master_volume = cfg_data[8:0];
					REG_TICK_DIVISOR:  tick_divisor  = cfg_data;
					default: ;
				endcase
			end

			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser) begin
					pending_samples.push_back({MID_LEVEL, 1'b0});
				end else begin
					pending_samples.push_back(mix_next_sample(voice_req_t'(s_axis_tdata)));
				end
			end
		end
		pending = pending_samples.size();
	end

endmodule

FILE: tb/sv/tb_four_voice_chiptune_mixer_top.sv
// Testbench top for the chiptune mixer: clock, reset, request and register stimulus, verdict.
`timescale 1ns / 1ps

module tb_four_voice_chiptune_mixer_top;

	import fvcm_pkg::*;
	import fvcm_tb_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int LONG_HOLD      = 400;
	localparam logic [CfgIndexW-1:0] REG_UNUSED = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [87:0] s_axis_tdata;   // voice_req_t, triangle_freq in the lowest bits
	logic        s_axis_tuser;   // hold
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;   // sample
	logic        m_axis_tuser;   // tick
	logic        cfg_valid;
	logic        cfg_ready;
	logic [CfgIndexW-1:0] cfg_index;
	logic [14:0] cfg_data;

	int   fail_count;
	int   pending;
	int   idle_cycles = 0;
	int   burst_left;
	logic long_hold_req;

	four_voice_chiptune_mixer_top uut (.*);

	fvcm_sample_checker sample_check (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Any cycle with a transfer on some channel restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("four_voice_chiptune_mixer_top verification failed");
			$finish;
		end
	end

	// The sink switches between stall patterns; on request it holds off for a long stretch.
	initial begin : receiver
		int   mode;
		int   span;
		int   pat;
		logic long_hold_done;

		m_axis_tready = 1'b0;
		pat = 0;
		long_hold_done = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(8, 80);
			repeat (span) begin
				@(negedge clk);
				if (long_hold_req && !long_hold_done) begin
					m_axis_tready = 1'b0;
					repeat (LONG_HOLD) @(negedge clk);
					long_hold_done = 1'b1;
				end
				pat++;
				case (mode)
					0: m_axis_tready = 1'b1;
					1: m_axis_tready = 1'($urandom_range(0, 1));
					2: m_axis_tready = ($urandom_range(0, 4) == 0);
					default: m_axis_tready = (pat % 7) > 2;
				endcase
			end
		end
	end

	function automatic voice_req_t make_req(input logic [15:0] tf, input logic [7:0] tv,
			input logic [15:0] pf, input logic [7:0] pv, input logic [15:0] sf,
			input logic [7:0] sv, input logic [7:0] nv, input logic [7:0] pcm);
		voice_req_t r;

		r.triangle_freq = tf;
		r.triangle_vol  = tv;
		r.pulse_freq    = pf;
		r.pulse_vol     = pv;
		r.square_freq   = sf;
		r.square_vol    = sv;
		r.noise_vol     = nv;
		r.pcm_level     = pcm;
		return r;
	endfunction

	// Slow phase increments are favored half the time so that whole waveforms get traced.
	function automatic voice_req_t rand_req();
		logic [95:0] raw;
		voice_req_t  r;

		raw = {$urandom, $urandom, $urandom};
		r = raw[87:0];
		if ($urandom_range(0, 1)) begin
			r.triangle_freq = r.triangle_freq >> 6;
		end
		if ($urandom_range(0, 1)) begin
			r.pulse_freq = r.pulse_freq >> 6;
		end
		if ($urandom_range(0, 1)) begin
			r.square_freq = r.square_freq >> 6;
		end
		if ($urandom_range(0, 1)) begin
			r.pcm_level = MID_LEVEL;
		end
		return r;
	endfunction

	// Offers one request and waits for its transfer; bursts end in a random gap or none.
	task automatic push_request(input voice_req_t r, input logic hold_bit);
		int gap;

		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = r;
		s_axis_tuser  = hold_bit;
		do @(posedge clk); while (!s_axis_tready);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 15);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				@(negedge clk);
				s_axis_tvalid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	task automatic drain();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic run_random(input int count);
		for (int i = 0; i < count; i++) begin
			push_request(rand_req(), $urandom_range(0, 11) == 0);
		end
		drain();
	endtask

	task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [14:0] value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	initial begin : stimulus
		logic [14:0] gain;

		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_MASTER_VOLUME;
		cfg_data      = '0;
		long_hold_req = 1'b0;
		burst_left    = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// Field extremes at the reset settings.
		push_request(make_req(16'h0, 8'h00, 16'h0, 8'h00, 16'h0, 8'h00, 8'h00, 8'h80), 1'b0);
		push_request('1, 1'b1);
		push_request(make_req(16'hFFFF, 8'h7F, 16'h0, 8'h00, 16'h0, 8'h00, 8'h00, 8'h80), 1'b0);
		push_request(make_req(16'h8000, 8'h80, 16'h0, 8'h00, 16'h0, 8'h00, 8'h00, 8'h80), 1'b0);
		// The pulse phase lands exactly on its edge with an amplitude of -128.
		push_request(make_req(16'h0, 8'h00, 16'hC000, 8'h80, 16'h0, 8'h00, 8'h00, 8'h80), 1'b0);
		push_request(make_req(16'h0, 8'h00, 16'hFFFF, 8'h7F, 16'h0, 8'h00, 8'h00, 8'h80), 1'b0);
		push_request(make_req(16'h0, 8'h00, 16'h0, 8'h00, 16'h8000, 8'h80, 8'h00, 8'h80), 1'b0);
		push_request(make_req(16'h0, 8'h00, 16'h0, 8'h00, 16'hFFFF, 8'h7F, 8'h00, 8'h80), 1'b0);
		push_request(make_req(16'h0, 8'h00, 16'h0, 8'h00, 16'h0, 8'h00, 8'h80, 8'h00), 1'b0);
		push_request(make_req(16'h0, 8'h00, 16'h0, 8'h00, 16'h0, 8'h00, 8'h7F, 8'hFF), 1'b0);
		push_request(make_req(16'hFFFF, 8'h7F, 16'hFFFF, 8'h7F, 16'hFFFF, 8'h7F, 8'h7F, 8'hFF),
			1'b0);
		push_request(make_req(16'h4000, 8'h80, 16'h4000, 8'h80, 16'h4000, 8'h80, 8'h80, 8'h00),
			1'b0);
		push_request(make_req(16'h0, 8'h00, 16'h0, 8'h00, 16'h0, 8'h00, 8'h00, 8'h00), 1'b1);
		push_request(make_req(16'h0123, 8'h40, 16'h2000, 8'hC0, 16'h1000, 8'h20, 8'hE0, 8'h80),
			1'b0);
		drain();

		// Silent gain with a tick on every normal sample.
		write_reg(REG_MASTER_VOLUME, 15'd0);
		write_reg(REG_TICK_DIVISOR, 15'd1);
		run_random(60);

		// All data bits set: gain above unity saturates, and a zero divisor ticks every normal sample.
		write_reg(REG_MASTER_VOLUME, 15'h7FFF);
		write_reg(REG_TICK_DIVISOR, 15'd0);
		write_reg(REG_UNUSED, 15'h5555);
		run_random(60);

		write_reg(REG_MASTER_VOLUME, 15'(UNITY_GAIN));
		write_reg(REG_TICK_DIVISOR, 15'd31250);
		run_random(60);
		// The running count is now above the new divisor, so the next normal sample wraps.
		write_reg(REG_TICK_DIVISOR, 15'd3);
		run_random(30);
		write_reg(REG_TICK_DIVISOR, 15'h7FFF);
		run_random(20);

		for (int i = 0; i < 6; i++) begin
			case (i)
				0: gain = 15'd1;
				1: gain = 15'd255;
				2: gain = 15'd257;
				default: gain = 15'($urandom_range(0, 511));
			endcase
			write_reg(REG_MASTER_VOLUME, gain);
			write_reg(REG_TICK_DIVISOR, 15'($urandom_range(1, 24)));
			if (i == 2) begin
				long_hold_req = 1'b1;
			end
			run_random(68);
		end

		if (fail_count == 0) begin
			$display("four_voice_chiptune_mixer_top verification clean");
		end else begin
			$display("four_voice_chiptune_mixer_top verification failed");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/fvcm_pkg.sv
rtl/core/fvcm_seq.sv
rtl/core/four_voice_chiptune_mixer_top.sv
rtl/core/fvcm_checker.sv
tb/sv/fvcm_sample_checker.sv
tb/sv/tb_four_voice_chiptune_mixer_top.sv
